// File: src/qdt_pkg.sv
// Shared types and constants for the quote-aware delimiter tokenizer.
// Used by qdt_cfg_regs, qdt_core and the top level; no dependencies.
`timescale 1ns / 1ps

package qdt_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned NumDelimRegs = 4;
  localparam int unsigned MaxDelims    = 4;
  localparam int unsigned DelimCntW    = 3;
  localparam int unsigned CfgIdxW      = 3;

  // Delimiter slots actually compared: the smaller of the register count and the limit
  localparam int unsigned DelimLimit =
      (MaxDelims < NumDelimRegs) ? MaxDelims : NumDelimRegs;

  // Register index map
  localparam logic [CfgIdxW-1:0] CFG_DELIM_0     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELIM_COUNT = 3'd4;

  // Reset values
  localparam logic [ByteW-1:0]     DELIM_0_RST     = 8'd32;
  localparam logic [ByteW-1:0]     DELIM_1_RST     = 8'd9;
  localparam logic [ByteW-1:0]     DELIM_2_RST     = 8'd0;
  localparam logic [ByteW-1:0]     DELIM_3_RST     = 8'd0;
  localparam logic [DelimCntW-1:0] DELIM_COUNT_RST = 3'd1;

  // Quote marks
  localparam logic [ByteW-1:0] DQ_MARK = 8'h22;
  localparam logic [ByteW-1:0] SQ_MARK = 8'h27;

  typedef struct packed {
    logic [NumDelimRegs-1:0][ByteW-1:0] delim;
    logic [DelimCntW-1:0]               count;
  } delim_cfg_t;

endpackage

// File: src/qdt_cfg_regs.sv
// Delimiter configuration registers with the plain write port decode.
// Depends on qdt_pkg.
`timescale 1ns / 1ps

module qdt_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [qdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qdt_pkg::ByteW-1:0]   cfg_data_i,
  output qdt_pkg::delim_cfg_t         cfg_o
);

  qdt_pkg::delim_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      if (cfg_idx_i < qdt_pkg::CFG_DELIM_COUNT) begin
        cfg_d.delim[cfg_idx_i[1:0]] = cfg_data_i;
      end else if (cfg_idx_i == qdt_pkg::CFG_DELIM_COUNT) begin
        cfg_d.count = cfg_data_i[qdt_pkg::DelimCntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim[0] <= qdt_pkg::DELIM_0_RST;
      cfg_q.delim[1] <= qdt_pkg::DELIM_1_RST;
      cfg_q.delim[2] <= qdt_pkg::DELIM_2_RST;
      cfg_q.delim[3] <= qdt_pkg::DELIM_3_RST;
      cfg_q.count    <= qdt_pkg::DELIM_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/qdt_core.sv
// Tokenizer datapath: input register, quote/token state, result register.
// Depends on qdt_pkg; delimiter settings come from qdt_cfg_regs.
`timescale 1ns / 1ps

module qdt_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qdt_pkg::delim_cfg_t       cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [qdt_pkg::ByteW-1:0] in_ch_i,
  input  logic                      in_eot_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [qdt_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_byte_valid_o,
  output logic                      out_token_end_o,
  output logic                      out_list_end_o
);

  // Input stage
  logic                      in_valid_q, in_valid_d;
  logic [qdt_pkg::ByteW-1:0] in_ch_q;
  logic                      in_eot_q;

  // Tokenizer state
  logic dq_q, dq_d;
  logic sq_q, sq_d;
  logic tne_q, tne_d;

  // Result stage
  logic                      out_valid_q, out_valid_d;
  logic [qdt_pkg::ByteW-1:0] res_byte_q, res_byte_d;
  logic                      res_bv_q, res_bv_d;
  logic                      res_te_q, res_te_d;
  logic                      res_le_q, res_le_d;

  logic advance;
  logic has_res;
  logic delim_hit;
  logic quoted;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    delim_hit = 1'b0;
    for (int k = 0; k < qdt_pkg::NumDelimRegs; k++) begin
      if ((k < qdt_pkg::DelimLimit) && (k < int'(cfg_i.count)) &&
          (cfg_i.delim[k] == in_ch_q)) begin
        delim_hit = 1'b1;
      end
    end
  end

  assign quoted = dq_q || sq_q;

  always_comb begin
    dq_d       = dq_q;
    sq_d       = sq_q;
    tne_d      = tne_q;
    has_res    = 1'b0;
    res_byte_d = '0;
    res_bv_d   = 1'b0;
    res_te_d   = 1'b0;
    res_le_d   = 1'b0;
    priority if (in_eot_q) begin
      // End of text closes the list even inside an open quote
      has_res  = 1'b1;
      res_te_d = tne_q;
      res_le_d = 1'b1;
      dq_d     = 1'b0;
      sq_d     = 1'b0;
      tne_d    = 1'b0;
    end else if (!quoted && delim_hit) begin
      // Drop delimiters that would close an empty token
      has_res  = tne_q;
      res_te_d = 1'b1;
      tne_d    = 1'b0;
    end else if ((in_ch_q == qdt_pkg::DQ_MARK) && !sq_q) begin
      dq_d = !dq_q;
    end else if ((in_ch_q == qdt_pkg::SQ_MARK) && !dq_q) begin
      sq_d = !sq_q;
    end else begin
      has_res    = 1'b1;
      res_byte_d = in_ch_q;
      res_bv_d   = 1'b1;
      tne_d      = 1'b1;
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = has_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dq_q        <= 1'b0;
      sq_q        <= 1'b0;
      tne_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        dq_q  <= dq_d;
        sq_q  <= sq_d;
        tne_q <= tne_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_ch_q  <= in_ch_i;
      in_eot_q <= in_eot_i;
    end
    if (advance && has_res) begin
      res_byte_q <= res_byte_d;
      res_bv_q   <= res_bv_d;
      res_te_q   <= res_te_d;
      res_le_q   <= res_le_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = res_byte_q;
  assign out_byte_valid_o = res_bv_q;
  assign out_token_end_o  = res_te_q;
  assign out_list_end_o   = res_le_q;

endmodule

// File: src/quoted_delimiter_tokenizer_unit.sv
// Path: a byte accepted at the input passes through the input register, then the
//   result register, before its result can transfer.
// Throughput: one byte per cycle unless the output stalls, set by the single-pass
//   decision between the two registers; quote marks and dropped delimiters give
//   no transfer.
// Reset: rst_ni clears quote and token state, both stage valids, and loads
//   the delimiter registers with their defaults.
`timescale 1ns / 1ps

module quoted_delimiter_tokenizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [qdt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qdt_pkg::ByteW-1:0]   cfg_data_i,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] ch
  input  logic                        s_axis_tlast,  // end_of_text
  // Output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]                  m_axis_tuser,  // [0] byte_valid, [1] token_end
  output logic                        m_axis_tlast   // list_end
);

  qdt_pkg::delim_cfg_t cfg;

  qdt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  qdt_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_ch_i          (s_axis_tdata),
    .in_eot_i         (s_axis_tlast),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (m_axis_tdata),
    .out_byte_valid_o (m_axis_tuser[0]),
    .out_token_end_o  (m_axis_tuser[1]),
    .out_list_end_o   (m_axis_tlast)
  );

endmodule

// File: src/qdt_checker.sv
// Port-level checks for quoted_delimiter_tokenizer_unit, attached by bind.
// Depends on the top-level port list only.
`timescale 1ns / 1ps

module qdt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  // A list end carries no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0] && (m_axis_tdata == 8'd0))
    else $error("list end carries a byte");

  // A token byte never closes a token in the same transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("byte and token end in one transfer");

  // Every transfer means something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tuser[1] || m_axis_tlast)
    else $error("empty output transfer");

endmodule

bind quoted_delimiter_tokenizer_unit qdt_checker u_qdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
